/* rtl/core/lr_pkg.sv */
// Shared constants, types and helpers of the line rasterizer.
package lr_pkg;

   localparam int COORD_BITS = 12;
   localparam int POS_BITS   = COORD_BITS + 1;
   localparam int SPAN_BITS  = COORD_BITS;
   localparam int INC_BITS   = COORD_BITS + 1;
   localparam int ACC_BITS   = COORD_BITS + 3;
   localparam int DIM_BITS   = 13;
   localparam int ADDR_BITS  = 24;
   localparam int COLOR_BITS = 32;
   localparam int PROD_BITS  = DIM_BITS + COORD_BITS;
   localparam int CMP_BITS   = (POS_BITS > DIM_BITS) ? POS_BITS : DIM_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OCNT_BITS   = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef struct packed {
      logic                       is_start;
      logic                       steep;
      logic signed [POS_BITS-1:0] major_pos;
      logic signed [POS_BITS-1:0] minor_pos;
      logic signed [POS_BITS-1:0] major_end;
      logic [SPAN_BITS-1:0]       span;
      logic [INC_BITS-1:0]        inc;
      logic                       minor_up;
      logic [COLOR_BITS-1:0]      color;
   } lr_cmd_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 head_valid;
   } lr_queue_status_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0] color;
      logic                  write_enable;
      logic                  last_pixel;
   } lr_pixel_type;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic signed [POS_BITS-1:0] d);
      logic signed [POS_BITS-1:0] n;
      n = -d;
      return d[POS_BITS-1] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

endpackage

/* rtl/core/lr_if.sv */
// Valid/ready channel interfaces for line commands and pixel results.
interface lr_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     op;
   logic signed [lr_pkg::COORD_BITS-1:0]     start_x;
   logic signed [lr_pkg::COORD_BITS-1:0]     start_y;
   logic signed [lr_pkg::COORD_BITS-1:0]     end_x;
   logic signed [lr_pkg::COORD_BITS-1:0]     end_y;
   logic [lr_pkg::COLOR_BITS-1:0]            line_color;

   modport source (output valid, op, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface lr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lr_pkg::ADDR_BITS-1:0]   pixel_address;
   logic [lr_pkg::COLOR_BITS-1:0]  pixel_color;
   logic                           write_enable;
   logic                           last_pixel;

   modport source (output valid, pixel_address, pixel_color, write_enable, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_address, pixel_color, write_enable, last_pixel,
                   output ready);
endinterface

/* rtl/core/lr_front.sv */
// Front end: accepts items, classifies them and prepares line setup for the queue.
module lr_front (
   input  logic                        clock,
   input  logic                        reset,
   lr_req_if.sink                      req_chan,
   input  lr_pkg::lr_queue_status_type queue_status,
   output logic                        push_valid,
   output lr_pkg::lr_cmd_type          push_cmd
);

   logic [lr_pkg::QCNT_BITS:0] occupancy;
   logic accept;

   logic signed [lr_pkg::POS_BITS-1:0] sx, sy, ex, ey, dx, dy;
   logic steep;

   logic                                f1_valid_ff;
   logic                                f1_is_start_ff;
   logic                                f1_steep_ff;
   logic signed [lr_pkg::POS_BITS-1:0]  f1_ax_ff, f1_ay_ff, f1_bx_ff, f1_by_ff;
   logic [lr_pkg::COLOR_BITS-1:0]       f1_color_ff;

   logic                                swap;
   logic signed [lr_pkg::POS_BITS-1:0]  maj_lo, min_lo, maj_hi, min_hi, span_full, dminor;

   // Keep room in the queue for every item already accepted, including the one in the input register.
   assign occupancy = {1'b0, queue_status.count} + (lr_pkg::QCNT_BITS + 1)'(f1_valid_ff);
   assign req_chan.ready = occupancy < (lr_pkg::QCNT_BITS + 1)'(lr_pkg::QUEUE_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   assign sx = {req_chan.start_x[lr_pkg::COORD_BITS-1], req_chan.start_x};
   assign sy = {req_chan.start_y[lr_pkg::COORD_BITS-1], req_chan.start_y};
   assign ex = {req_chan.end_x[lr_pkg::COORD_BITS-1], req_chan.end_x};
   assign ey = {req_chan.end_y[lr_pkg::COORD_BITS-1], req_chan.end_y};
   assign dx = sx - ex;
   assign dy = sy - ey;
   assign steep = lr_pkg::abs_diff(dx) < lr_pkg::abs_diff(dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
      f1_is_start_ff <= req_chan.op == lr_pkg::OP_START;
      f1_steep_ff    <= steep;
      f1_ax_ff       <= steep ? sy : sx;
      f1_ay_ff       <= steep ? sx : sy;
      f1_bx_ff       <= steep ? ey : ex;
      f1_by_ff       <= steep ? ex : ey;
      f1_color_ff    <= req_chan.line_color;
   end

   assign swap      = f1_ax_ff > f1_bx_ff;
   assign maj_lo    = swap ? f1_bx_ff : f1_ax_ff;
   assign min_lo    = swap ? f1_by_ff : f1_ay_ff;
   assign maj_hi    = swap ? f1_ax_ff : f1_bx_ff;
   assign min_hi    = swap ? f1_ay_ff : f1_by_ff;
   assign span_full = maj_hi - maj_lo;
   assign dminor    = min_hi - min_lo;

   always_comb begin
      push_valid         = f1_valid_ff;
      push_cmd.is_start  = f1_is_start_ff;
      push_cmd.steep     = f1_steep_ff;
      push_cmd.major_pos = maj_lo;
      push_cmd.minor_pos = min_lo;
      push_cmd.major_end = maj_hi;
      push_cmd.span      = span_full[lr_pkg::SPAN_BITS-1:0];
      push_cmd.inc       = {lr_pkg::abs_diff(dminor), 1'b0};
      push_cmd.minor_up  = min_hi > min_lo;
      push_cmd.color     = f1_color_ff;
   end

endmodule

/* rtl/core/lr_cmd_queue.sv */
// Short command queue between the front end and the pixel stepper.
module lr_cmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lr_pkg::lr_cmd_type          push_cmd,
   input  logic                        pop,
   output lr_pkg::lr_queue_status_type status,
   output lr_pkg::lr_cmd_type          head_cmd
);

   lr_pkg::lr_cmd_type              mem_ff [lr_pkg::QUEUE_DEPTH];
   logic [lr_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lr_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lr_pkg::QCNT_BITS-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + lr_pkg::QCNT_BITS'(push) - lr_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign status.count      = count_ff;
   assign status.head_valid = count_ff != '0;
   assign head_cmd          = mem_ff[rd_ptr_ff];

endmodule

/* rtl/core/lr_back.sv */
// Back end: Bresenham stepper, address pipeline and result queue.
module lr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  lr_pkg::lr_queue_status_type    queue_status,
   input  lr_pkg::lr_cmd_type             head_cmd,
   input  logic [lr_pkg::DIM_BITS-1:0]    frame_width,
   input  logic [lr_pkg::DIM_BITS-1:0]    frame_height,
   output logic                           pop,
   lr_rsp_if.source                       rsp_chan
);

   logic                                active_ff, active_in;
   logic                                steep_ff, steep_in;
   logic signed [lr_pkg::POS_BITS-1:0]  major_pos_ff, major_pos_in;
   logic signed [lr_pkg::POS_BITS-1:0]  minor_pos_ff, minor_pos_in;
   logic signed [lr_pkg::POS_BITS-1:0]  major_end_ff, major_end_in;
   logic [lr_pkg::SPAN_BITS-1:0]        span_ff, span_in;
   logic [lr_pkg::INC_BITS-1:0]         inc_ff, inc_in;
   logic signed [lr_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic                                minor_up_ff, minor_up_in;
   logic [lr_pkg::COLOR_BITS-1:0]       color_ff, color_in;

   logic signed [lr_pkg::POS_BITS-1:0]  px, py;
   logic                                last, in_frame;
   logic signed [lr_pkg::ACC_BITS-1:0]  acc_sum, acc_back, span_ext;

   logic                                s1_valid_ff, s1_valid_in;
   logic [lr_pkg::COORD_BITS-1:0]       s1_px_ff, s1_py_ff;
   logic                                s1_inside_ff, s1_last_ff;
   logic [lr_pkg::COLOR_BITS-1:0]       s1_color_ff;

   logic                                s2_valid_ff;
   logic [lr_pkg::PROD_BITS-1:0]        s2_prod_ff;
   logic [lr_pkg::COORD_BITS-1:0]       s2_px_ff;
   logic                                s2_inside_ff, s2_last_ff;
   logic [lr_pkg::COLOR_BITS-1:0]       s2_color_ff;

   lr_pkg::lr_pixel_type                out_mem_ff [lr_pkg::OUT_DEPTH];
   lr_pkg::lr_pixel_type                out_pixel;
   logic [lr_pkg::PROD_BITS-1:0]        addr_sum;
   logic [lr_pkg::OPTR_BITS-1:0]        owr_ptr_ff, owr_ptr_in, ord_ptr_ff, ord_ptr_in;
   logic [lr_pkg::OCNT_BITS-1:0]        ocount_ff, ocount_in;
   logic [lr_pkg::OCNT_BITS:0]          in_flight;
   logic                                out_pop;

   // A command is taken only when the result queue can absorb everything in flight.
   assign in_flight = {1'b0, ocount_ff} + (lr_pkg::OCNT_BITS + 1)'(s1_valid_ff)
                      + (lr_pkg::OCNT_BITS + 1)'(s2_valid_ff);
   assign pop = queue_status.head_valid
                && (in_flight < (lr_pkg::OCNT_BITS + 1)'(lr_pkg::OUT_DEPTH));

   assign px       = steep_ff ? minor_pos_ff : major_pos_ff;
   assign py       = steep_ff ? major_pos_ff : minor_pos_ff;
   assign last     = major_pos_ff >= major_end_ff;
   assign in_frame = !px[lr_pkg::POS_BITS-1] && !py[lr_pkg::POS_BITS-1]
                     && (lr_pkg::CMP_BITS'(px[lr_pkg::COORD_BITS-1:0])
                         < lr_pkg::CMP_BITS'(frame_width))
                     && (lr_pkg::CMP_BITS'(py[lr_pkg::COORD_BITS-1:0])
                         < lr_pkg::CMP_BITS'(frame_height));

   assign span_ext = $signed(lr_pkg::ACC_BITS'(span_ff));
   assign acc_sum  = acc_ff + $signed(lr_pkg::ACC_BITS'(inc_ff));
   assign acc_back = acc_sum - $signed(lr_pkg::ACC_BITS'({span_ff, 1'b0}));

   always_comb begin
      active_in    = active_ff;
      steep_in     = steep_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_end_in = major_end_ff;
      span_in      = span_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      minor_up_in  = minor_up_ff;
      color_in     = color_ff;
      s1_valid_in  = 1'b0;
      if (pop) begin
         if (head_cmd.is_start) begin
            active_in    = 1'b1;
            steep_in     = head_cmd.steep;
            major_pos_in = head_cmd.major_pos;
            minor_pos_in = head_cmd.minor_pos;
            major_end_in = head_cmd.major_end;
            span_in      = head_cmd.span;
            inc_in       = head_cmd.inc;
            acc_in       = '0;
            minor_up_in  = head_cmd.minor_up;
            color_in     = head_cmd.color;
         end else if (active_ff) begin
            s1_valid_in  = 1'b1;
            major_pos_in = major_pos_ff + lr_pkg::POS_BITS'(1);
            if (acc_sum > span_ext) begin
               minor_pos_in = minor_up_ff ? minor_pos_ff + lr_pkg::POS_BITS'(1)
                                          : minor_pos_ff - lr_pkg::POS_BITS'(1);
               acc_in       = acc_back;
            end else begin
               acc_in       = acc_sum;
            end
            if (last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      steep_ff     <= steep_in;
      major_pos_ff <= major_pos_in;
      minor_pos_ff <= minor_pos_in;
      major_end_ff <= major_end_in;
      span_ff      <= span_in;
      inc_ff       <= inc_in;
      acc_ff       <= acc_in;
      minor_up_ff  <= minor_up_in;
      color_ff     <= color_in;

      s1_px_ff     <= px[lr_pkg::COORD_BITS-1:0];
      s1_py_ff     <= py[lr_pkg::COORD_BITS-1:0];
      s1_inside_ff <= in_frame;
      s1_last_ff   <= last;
      s1_color_ff  <= color_ff;

      s2_prod_ff   <= frame_width * s1_py_ff;
      s2_px_ff     <= s1_px_ff;
      s2_inside_ff <= s1_inside_ff;
      s2_last_ff   <= s1_last_ff;
      s2_color_ff  <= s1_color_ff;
   end

   assign addr_sum = s2_prod_ff + lr_pkg::PROD_BITS'(s2_px_ff);

   always_comb begin
      out_pixel.addr         = s2_inside_ff ? lr_pkg::ADDR_BITS'(addr_sum) : '0;
      out_pixel.color        = s2_color_ff;
      out_pixel.write_enable = s2_inside_ff;
      out_pixel.last_pixel   = s2_last_ff;
   end

   assign out_pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      owr_ptr_in = s2_valid_ff ? owr_ptr_ff + 1'b1 : owr_ptr_ff;
      ord_ptr_in = out_pop ? ord_ptr_ff + 1'b1 : ord_ptr_ff;
      ocount_in  = ocount_ff + lr_pkg::OCNT_BITS'(s2_valid_ff)
                   - lr_pkg::OCNT_BITS'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocount_ff  <= '0;
      end else begin
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocount_ff  <= ocount_in;
      end
      if (s2_valid_ff) begin
         out_mem_ff[owr_ptr_ff] <= out_pixel;
      end
   end

   assign rsp_chan.valid         = ocount_ff != '0;
   assign rsp_chan.pixel_address = out_mem_ff[ord_ptr_ff].addr;
   assign rsp_chan.pixel_color   = out_mem_ff[ord_ptr_ff].color;
   assign rsp_chan.write_enable  = out_mem_ff[ord_ptr_ff].write_enable;
   assign rsp_chan.last_pixel    = out_mem_ff[ord_ptr_ff].last_pixel;

endmodule

/* rtl/core/line_rasterizer_unit.sv */
// Top level of the Bresenham line rasterizer.
//
//   channel   dir  handshake          carries
//   req_chan  in   valid/ready        op, start_x, start_y, end_x, end_y, line_color
//   rsp_chan  out  valid/ready        pixel_address, pixel_color, write_enable, last_pixel
//   csr_*     in   write enable only  frame_width (index 0), frame_height (index 1)
//
// One item is accepted per cycle while req_chan.ready is high; each active step item yields
// one pixel, with the stepper's error update setting that rate.
// After its step item is accepted, a pixel passes the input register, command queue, stepper,
// multiplier register and result queue before it is offered, the first loaded at the accepting edge.
// Reset is synchronous; no clearing pass is needed and items are taken the cycle after.
// A stalled result side fills the result queue and then the command queue before
// req_chan.ready falls.
module line_rasterizer_unit (
   input  logic                              clock,
   input  logic                              reset,
   lr_req_if.sink                            req_chan,
   lr_rsp_if.source                          rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [lr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lr_pkg::DIM_BITS-1:0]       csr_write_data
);

   logic [lr_pkg::DIM_BITS-1:0] frame_width_ff, frame_width_in;
   logic [lr_pkg::DIM_BITS-1:0] frame_height_ff, frame_height_in;

   logic                        push_valid;
   lr_pkg::lr_cmd_type          push_cmd;
   lr_pkg::lr_cmd_type          head_cmd;
   lr_pkg::lr_queue_status_type queue_status;
   logic                        pop;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lr_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            lr_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lr_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lr_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   lr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd)
   );

   lr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .status   (queue_status),
      .head_cmd (head_cmd)
   );

   lr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

/* rtl/core/lr_checker.sv */
// Port-level checks of the line rasterizer and their binding to the top level.
module lr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lr_pkg::ADDR_BITS-1:0]  pixel_address,
   input logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
   input logic                          write_enable,
   input logic                          last_pixel
);

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Reset empties the command path, so items are taken at once.
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   // A clipped pixel carries a zero address.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !write_enable |-> pixel_address == '0)
      else $error("clipped pixel with nonzero address");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=>
                    rsp_valid && $stable({pixel_address, pixel_color, write_enable, last_pixel}))
      else $error("stalled result changed");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .pixel_address (rsp_chan.pixel_address),
   .pixel_color   (rsp_chan.pixel_color),
   .write_enable  (rsp_chan.write_enable),
   .last_pixel    (rsp_chan.last_pixel)
);
